// File: src/rtph_pkg.sv
// Shared types and constants for the rectangle table hit test block.
// No dependencies.
package rtph_pkg;

  localparam int unsigned COORD_W = 14;
  localparam int unsigned POS_W   = 13;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_QUERY  = 3'd5
  } cmd_t;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] wid;
    logic [COORD_W-1:0] hgt;
  } rect_t;

  typedef enum logic [2:0] {
    CM_HOLD, CM_INSERT, CM_REMOVE, CM_WRITE, CM_ROTATE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

endpackage

// File: src/rtph_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on rtph_pkg.
interface rtph_req_if import rtph_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [9:0]         index;
  logic [COORD_W-1:0] left;
  logic [COORD_W-1:0] top;
  logic [COORD_W-1:0] width;
  logic [COORD_W-1:0] height;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  modport source (output valid, command, index, left, top, width, height, point_x, point_y,
                  input ready);
  modport sink (input valid, command, index, left, top, width, height, point_x, point_y,
                output ready);
endinterface

interface rtph_rsp_if import rtph_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [7:0]         found_index;
  logic               hit;
  logic [COORD_W-1:0] out_left;
  logic [COORD_W-1:0] out_top;
  logic [COORD_W-1:0] out_width;
  logic [COORD_W-1:0] out_height;
  logic [8:0]         entry_count;
  logic [1:0]         status;
  modport source (output valid, found_index, hit, out_left, out_top, out_width, out_height,
                  entry_count, status, input ready);
  modport sink (input valid, found_index, hit, out_left, out_top, out_width, out_height,
                entry_count, status, output ready);
endinterface

// File: src/rtph_cell.sv
// One table slot: holds a rectangle and moves it to or from its neighbors.
// Depends on rtph_pkg.
module rtph_cell import rtph_pkg::*; #(
  parameter int unsigned POS = 0
) (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  rect_t      new_rect,
  input  rect_t      prev_rect,
  input  rect_t      next_rect,
  output rect_t      rect
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

  rect_t rect_next;

  always_comb begin
    rect_next = rect;
    case (ctrl.mode)
      CM_INSERT: begin
        if (MY_POS > ctrl.pos) rect_next = prev_rect;
        else if (MY_POS == ctrl.pos) rect_next = new_rect;
      end
      CM_REMOVE: begin
        if (MY_POS >= ctrl.pos) rect_next = next_rect;
      end
      CM_WRITE: begin
        if (MY_POS == ctrl.pos) rect_next = new_rect;
      end
      CM_ROTATE: rect_next = next_rect;
      default: rect_next = rect;
    endcase
  end

  always_ff @(posedge clk) begin
    rect <= rect_next;
  end

endmodule

// File: src/rect_table_point_hit_test.sv
// Rectangle table with point hit test: top level with the cell ring and scan.
// Depends on rtph_pkg, rtph_if and rtph_cell.
//
// Usage: requests arrive on the req channel (command, index, rectangle and
// point fields); exactly one response per request leaves on the rsp channel.
// Clear, insert, remove, overwrite, unknown codes and any out-of-range or
// full case finish in the cycle of the transfer: the response is valid on
// the next cycle. Read and point query rotate the whole ring of MAX_RECTS
// cells past one evaluator, one entry a cycle, and the response is
// registered once the whole ring has passed.
// One request is worked on at a time; a new request is taken once the block
// is idle and the response register is empty or being drained.
// If the receiver stalls, the response holds and the block waits.
// Reset empties the table (count zero) and drops any pending response;
// stored rectangles are not cleared and are never read before written.
module rect_table_point_hit_test import rtph_pkg::*; #(
  parameter int unsigned MAX_RECTS = 256
) (
  input  logic       clk,
  input  logic       rst,
  rtph_req_if.sink   req,
  rtph_rsp_if.source rsp
);

  localparam int unsigned IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECTS + 1);
  localparam logic [IW-1:0] LAST = IW'(MAX_RECTS - 1);

  state_t        state, state_next;
  logic [CW-1:0] count;
  logic [IW-1:0] k;
  cmd_t          cmd;
  logic [9:0]    idx;
  logic [COORD_W-1:0] px, py;

  logic          found_hit, have_best;
  logic [IW-1:0] found;
  logic [15:0]   best;
  rect_t         rd_rect;

  rect_t      cells [MAX_RECTS];
  cell_ctrl_t ctrl;
  rect_t      new_rect;

  logic take, rsp_free, in_range, is_full;
  logic [31:0] idx32, cnt32, ins_pos;

  assign rsp_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && rsp_free;
  assign take      = req.valid && req.ready;
  assign idx32     = 32'(req.index);
  assign cnt32     = 32'(count);
  assign in_range  = idx32 < cnt32;
  assign is_full   = cnt32 >= MAX_RECTS;
  assign ins_pos   = (idx32 > cnt32) ? cnt32 : idx32;
  assign new_rect  = '{left: req.left, top: req.top, wid: req.width, hgt: req.height};

  always_comb begin
    ctrl = '{mode: CM_HOLD, pos: '0};
    if (state == S_SCAN) begin
      ctrl.mode = CM_ROTATE;
    end else if (take) begin
      case (req.command)
        CMD_INSERT: if (!is_full) ctrl = '{mode: CM_INSERT, pos: POS_W'(ins_pos)};
        CMD_REMOVE: if (in_range) ctrl = '{mode: CM_REMOVE, pos: POS_W'(idx32)};
        CMD_WRITE:  if (in_range) ctrl = '{mode: CM_WRITE, pos: POS_W'(idx32)};
        default: ctrl.mode = CM_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    rtph_cell #(.POS(i)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_rect  (new_rect),
      .prev_rect (cells[(i + MAX_RECTS - 1) % MAX_RECTS]),
      .next_rect (cells[(i + 1) % MAX_RECTS]),
      .rect      (cells[i])
    );
  end

  // Evaluation of the entry currently at the head of the ring.
  rect_t       head;
  logic        head_live, in_rect;
  logic [15:0] sx, sy, d;
  logic [14:0] cx, cy, dx, dy;
  logic [14:0] ex, ey;

  assign head      = cells[0];
  assign head_live = CW'(k) < count;
  assign ex        = 15'(head.left) + 15'(head.wid);
  assign ey        = 15'(head.top) + 15'(head.hgt);
  assign in_rect   = (head.wid != '0) && (head.hgt != '0) &&
                     (px >= head.left) && (15'(px) < ex) &&
                     (py >= head.top) && (15'(py) < ey);
  assign sx = {1'b0, head.left, 1'b0} + 16'(head.wid);
  assign sy = {1'b0, head.top, 1'b0} + 16'(head.hgt);
  assign cx = (sx == '0) ? '0 : 15'((sx - 16'd1) >> 1);
  assign cy = (sy == '0) ? '0 : 15'((sy - 16'd1) >> 1);
  assign dx = (cx > 15'(px)) ? cx - 15'(px) : 15'(px) - cx;
  assign dy = (cy > 15'(py)) ? cy - 15'(py) : 15'(py) - cy;
  assign d  = 16'(dx) + 16'(dy);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (take && (req.command == CMD_QUERY ||
                           (req.command == CMD_READ && in_range))) state_next = S_SCAN;
      S_SCAN: if (k == LAST) state_next = S_DONE;
      S_DONE: if (rsp_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      if (take) begin
        case (req.command)
          CMD_CLEAR:  count <= '0;
          CMD_INSERT: if (!is_full) count <= count + 1'b1;
          CMD_REMOVE: if (in_range) count <= count - 1'b1;
          default: count <= count;
        endcase
        if (state_next == S_IDLE) rsp.valid <= 1'b1;
      end
      if (state == S_DONE && rsp_free) rsp.valid <= 1'b1;
    end
  end

  logic [31:0] found32, count32;
  assign found32 = 32'(found);
  assign count32 = 32'(count);

  always_ff @(posedge clk) begin
    if (take) begin
      cmd       <= cmd_t'(req.command);
      idx       <= req.index;
      px        <= req.point_x;
      py        <= req.point_y;
      k         <= '0;
      found     <= '0;
      found_hit <= 1'b0;
      have_best <= 1'b0;
      best      <= '0;
      rd_rect   <= '0;
    end else if (state == S_SCAN) begin
      k <= k + 1'b1;
      if (head_live) begin
        if (cmd == CMD_READ) begin
          if (32'(k) == 32'(idx)) rd_rect <= head;
        end else if (!found_hit) begin
          if (in_rect) begin
            found     <= k;
            found_hit <= 1'b1;
          end else if (!have_best || d < best) begin
            found     <= k;
            best      <= d;
            have_best <= 1'b1;
          end
        end
      end
    end
  end

  // Response payload.
  always_ff @(posedge clk) begin
    if (take && state_next == S_IDLE) begin
      rsp.found_index <= '0;
      rsp.hit         <= 1'b0;
      rsp.out_left    <= '0;
      rsp.out_top     <= '0;
      rsp.out_width   <= '0;
      rsp.out_height  <= '0;
      rsp.status      <= ST_DONE;
      case (req.command)
        CMD_CLEAR: rsp.entry_count <= '0;
        CMD_INSERT: begin
          if (is_full) begin
            rsp.status      <= ST_FULL;
            rsp.entry_count <= count32[8:0];
          end else begin
            rsp.entry_count <= 9'(count32 + 32'd1);
          end
        end
        CMD_REMOVE: begin
          if (in_range) rsp.entry_count <= 9'(count32 - 32'd1);
          else begin
            rsp.entry_count <= count32[8:0];
            rsp.status      <= ST_RANGE;
          end
        end
        CMD_WRITE, CMD_READ: begin
          rsp.entry_count <= count32[8:0];
          if (!in_range) rsp.status <= ST_RANGE;
        end
        default: rsp.entry_count <= count32[8:0];
      endcase
    end else if (state == S_DONE && rsp_free) begin
      rsp.entry_count <= count32[8:0];
      rsp.status      <= ST_DONE;
      if (cmd == CMD_READ) begin
        rsp.found_index <= '0;
        rsp.hit         <= 1'b0;
        rsp.out_left    <= rd_rect.left;
        rsp.out_top     <= rd_rect.top;
        rsp.out_width   <= rd_rect.wid;
        rsp.out_height  <= rd_rect.hgt;
      end else begin
        rsp.found_index <= found32[7:0];
        rsp.hit         <= found_hit;
        rsp.out_left    <= '0;
        rsp.out_top     <= '0;
        rsp.out_width   <= '0;
        rsp.out_height  <= '0;
      end
    end
  end

endmodule

// File: tb/rect_table_point_hit_test_tb.sv
// Testbench for the rectangle table with point hit test: drives commands on the
// request channel and checks every response against a table model kept here.
// Depends on rtph_pkg, rtph_if and the rect_table_point_hit_test RTL.
`timescale 1ns / 100ps

module rect_table_point_hit_test_tb import rtph_pkg::*; ();

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [7:0]         found_index;
    logic               hit;
    logic [COORD_W-1:0] out_left;
    logic [COORD_W-1:0] out_top;
    logic [COORD_W-1:0] out_width;
    logic [COORD_W-1:0] out_height;
    logic [8:0]         entry_count;
    logic [1:0]         status;
  } answer_t;

  logic clk;
  logic rst;
  rtph_req_if req ();
  rtph_rsp_if rsp ();

  rect_table_point_hit_test #(.MAX_RECTS(TABLE_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  rect_t       model_rects[TABLE_DEPTH];
  int unsigned model_count;
  answer_t     pending_answers[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          recv_hold;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [14:0] center_of(logic [COORD_W-1:0] lo, logic [COORD_W-1:0] len);
    logic [15:0] s;
    s = 16'(2 * lo + len);
    return (s == 0) ? 15'd0 : 15'((s - 1) / 2);
  endfunction

  function automatic bit covers(logic [COORD_W-1:0] lo, logic [COORD_W-1:0] len,
                                logic [COORD_W-1:0] p);
    return len != 0 && p >= lo && 32'(p) <= 32'(lo) + 32'(len) - 1;
  endfunction

  // Applies one command to the model table and returns the response it should give.
  function automatic answer_t apply_command(logic [2:0] cmd, logic [9:0] idx, rect_t r,
                                            logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    answer_t a;
    int unsigned pos;
    int unsigned best;
    int unsigned distance;
    bit done;
    a = '0;
    pos = idx;
    done = 0;
    best = 32'hFFFF_FFFF;
    case (cmd)
      CMD_CLEAR: model_count = 0;
      CMD_INSERT: begin
        if (model_count >= TABLE_DEPTH) begin
          a.status = ST_FULL;
        end else begin
          if (pos > model_count) pos = model_count;
          for (int i = model_count; i > pos; i--) model_rects[i] = model_rects[i-1];
          model_rects[pos] = r;
          model_count++;
        end
      end
      CMD_REMOVE: begin
        if (pos >= model_count) begin
          a.status = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < model_count; i++) model_rects[i] = model_rects[i+1];
          model_count--;
        end
      end
      CMD_WRITE: begin
        if (pos >= model_count) a.status = ST_RANGE;
        else model_rects[pos] = r;
      end
      CMD_READ: begin
        if (pos >= model_count) begin
          a.status = ST_RANGE;
        end else begin
          a.out_left   = model_rects[pos].left;
          a.out_top    = model_rects[pos].top;
          a.out_width  = model_rects[pos].wid;
          a.out_height = model_rects[pos].hgt;
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < model_count && !done; i++) begin
          if (covers(model_rects[i].left, model_rects[i].wid, px) &&
              covers(model_rects[i].top, model_rects[i].hgt, py)) begin
            a.found_index = 8'(i);
            a.hit = 1'b1;
            done = 1;
          end
        end
        if (!done) begin
          for (int i = 0; i < model_count; i++) begin
            distance = (center_of(model_rects[i].left, model_rects[i].wid) > px ?
                        center_of(model_rects[i].left, model_rects[i].wid) - px :
                        px - center_of(model_rects[i].left, model_rects[i].wid)) +
                       (center_of(model_rects[i].top, model_rects[i].hgt) > py ?
                        center_of(model_rects[i].top, model_rects[i].hgt) - py :
                        py - center_of(model_rects[i].top, model_rects[i].hgt));
            if (distance < best) begin
              best = distance;
              a.found_index = 8'(i);
            end
          end
        end
      end
      default: ;
    endcase
    a.entry_count = 9'(model_count);
    return a;
  endfunction

  task automatic send_command(logic [2:0] cmd, logic [9:0] idx, rect_t r,
                              logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    req.valid   <= 1'b1;
    req.command <= cmd;
    req.index   <= idx;
    req.left    <= r.left;
    req.top     <= r.top;
    req.width   <= r.wid;
    req.height  <= r.hgt;
    req.point_x <= px;
    req.point_y <= py;
    do @(posedge clk); while (!req.ready);
    pending_answers.push_back(apply_command(cmd, idx, r, px, py));
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  function automatic rect_t random_rect();
    rect_t r;
    case ($urandom_range(3))
      0: r = 56'({$urandom, $urandom});
      1: begin
        r.left = 14'($urandom_range(200));
        r.top  = 14'($urandom_range(200));
        r.wid  = 14'($urandom_range(60));
        r.hgt  = 14'($urandom_range(60));
      end
      default: begin
        r.left = 14'($urandom_range(16383));
        r.top  = 14'($urandom_range(16383));
        r.wid  = 14'($urandom_range(3000));
        r.hgt  = 14'($urandom_range(3000));
      end
    endcase
    return r;
  endfunction

  task automatic send_random(int unsigned n);
    logic [2:0] cmd;
    logic [9:0] idx;
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 30) cmd = CMD_INSERT;
      else if (pick < 45) cmd = CMD_REMOVE;
      else if (pick < 55) cmd = CMD_WRITE;
      else if (pick < 70) cmd = CMD_READ;
      else if (pick < 96) cmd = CMD_QUERY;
      else if (pick < 98) cmd = CMD_CLEAR;
      else cmd = 3'($urandom_range(7, 6));
      if ($urandom_range(9) == 0) idx = 10'($urandom);
      else idx = 10'($urandom_range(model_count + 1));
      if ($urandom_range(1)) begin
        send_command(cmd, idx, random_rect(), 14'($urandom_range(260)),
                     14'($urandom_range(260)));
      end else begin
        send_command(cmd, idx, random_rect(), 14'($urandom), 14'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    rect_t r;
    r = '0;
    send_command(CMD_QUERY, 10'd0, r, 14'd5, 14'd5);
    send_command(CMD_REMOVE, 10'd0, r, 14'd0, 14'd0);
    send_command(CMD_WRITE, 10'd0, r, 14'd0, 14'd0);
    send_command(CMD_READ, 10'd0, r, 14'd0, 14'd0);
    send_command(CMD_INSERT, 10'd1023, '{14'd10, 14'd10, 14'd5, 14'd5}, 14'd0, 14'd0);
    send_command(CMD_INSERT, 10'd0, '{14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF}, 14'd0, 14'd0);
    send_command(CMD_INSERT, 10'd1, '{14'd0, 14'd0, 14'd0, 14'd0}, 14'd0, 14'd0);
    send_command(CMD_INSERT, 10'd3, '{14'd10, 14'd10, 14'd5, 14'd5}, 14'd0, 14'd0);
    send_command(CMD_QUERY, 10'd0, r, 14'd14, 14'd10);
    send_command(CMD_QUERY, 10'd0, r, 14'd15, 14'd10);
    send_command(CMD_QUERY, 10'd0, r, 14'h3FFF, 14'h3FFF);
    send_command(CMD_QUERY, 10'd0, r, 14'd0, 14'd0);
    send_command(CMD_QUERY, 10'd0, r, 14'd12, 14'd40);
    send_command(CMD_READ, 10'd0, r, 14'd0, 14'd0);
    send_command(CMD_READ, 10'd4, r, 14'd0, 14'd0);
    send_command(CMD_WRITE, 10'd1, '{14'd3, 14'd3, 14'd1, 14'd1}, 14'd0, 14'd0);
    send_command(CMD_READ, 10'd1, r, 14'd0, 14'd0);
    send_command(CMD_REMOVE, 10'd0, r, 14'd0, 14'd0);
    send_command(CMD_REMOVE, 10'd1023, r, 14'd0, 14'd0);
    send_command(3'd6, 10'd0, r, 14'd0, 14'd0);
    send_command(3'd7, 10'h3FF, '1, 14'h3FFF, 14'h3FFF);
    send_command(CMD_CLEAR, 10'd0, r, 14'd0, 14'd0);
  endtask

  // Fills the table to its limit, then an insert must report full.
  task automatic test_full_table();
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      send_command(CMD_INSERT, 10'($urandom), random_rect(), 14'd0, 14'd0);
    end
    send_command(CMD_INSERT, 10'd0, random_rect(), 14'd0, 14'd0);
    for (int k = 0; k < 6; k++) begin
      send_command(CMD_QUERY, 10'd0, '0, 14'($urandom), 14'($urandom));
    end
    send_command(CMD_REMOVE, 10'd255, '0, 14'd0, 14'd0);
    send_command(CMD_REMOVE, 10'd0, '0, 14'd0, 14'd0);
    send_command(CMD_READ, 10'd253, '0, 14'd0, 14'd0);
    send_command(CMD_CLEAR, 10'd0, '0, 14'd0, 14'd0);
  endtask

  // The receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      send_random(12);
      begin
        repeat (3000) @(posedge clk);
        recv_hold = 1'b0;
      end
    join
  endtask

  task automatic test_random();
    send_idle_pct = 6;
    recv_idle_pct = 68;
    send_random(200);
    send_idle_pct = 68;
    recv_idle_pct = 6;
    send_random(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(150);
  endtask

  always @(negedge clk) begin
    rsp.ready <= !rst && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.found_index, rsp.hit, rsp.out_left, rsp.out_top, rsp.out_width,
              rsp.out_height, rsp.entry_count, rsp.status};
      if (pending_answers.size() == 0) begin
        $error("Response transfer with nothing expected");
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (got.found_index !== want.found_index) begin
          $error("found_index expected %0d got %0d", want.found_index, got.found_index);
          error_count++;
        end
        if (got.hit !== want.hit) begin
          $error("hit expected %0d got %0d", want.hit, got.hit);
          error_count++;
        end
        if (got.out_left !== want.out_left) begin
          $error("out_left expected %0d got %0d", want.out_left, got.out_left);
          error_count++;
        end
        if (got.out_top !== want.out_top) begin
          $error("out_top expected %0d got %0d", want.out_top, got.out_top);
          error_count++;
        end
        if (got.out_width !== want.out_width) begin
          $error("out_width expected %0d got %0d", want.out_width, got.out_width);
          error_count++;
        end
        if (got.out_height !== want.out_height) begin
          $error("out_height expected %0d got %0d", want.out_height, got.out_height);
          error_count++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count expected %0d got %0d", want.entry_count, got.entry_count);
          error_count++;
        end
        if (got.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, got.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    model_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.command = CMD_CLEAR;
    req.index = '0;
    req.left = '0;
    req.top = '0;
    req.width = '0;
    req.height = '0;
    req.point_x = '0;
    req.point_y = '0;
    rsp.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_full_table();
    test_random();
    wait_drained();
    repeat (2 * TABLE_DEPTH + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
